// File: hdl/hcw_pkg.sv
// ----------------------------------------------------------------------------
// hcw_pkg
// Shared types, protocol numbers and verdict codes of the header chain walker.
// ----------------------------------------------------------------------------
package hcw_pkg;

   localparam int DEF_MAX_DEPTH     = 8;
   localparam int DEF_OFFSET_LIMIT  = 255;
   localparam int DEF_POSITION_BITS = 12;

   localparam logic [7:0] PROTO_IPIP    = 8'd4;
   localparam logic [7:0] PROTO_TCP     = 8'd6;
   localparam logic [7:0] PROTO_IPV6    = 8'd41;
   localparam logic [7:0] PROTO_ROUTING = 8'd43;

   localparam logic [7:0] FIRST_TYPE_RESET = PROTO_IPV6;
   localparam logic [7:0] SRH_TYPE_RESET   = 8'd4;

   localparam logic [2:0] ST_TCP_FOUND   = 3'd0;
   localparam logic [2:0] ST_DEPTH       = 3'd1;
   localparam logic [2:0] ST_TRUNCATED   = 3'd2;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
   localparam logic [2:0] ST_OVERFLOW    = 3'd4;
   localparam logic [2:0] ST_BAD_IHL     = 3'd5;

   localparam logic CSR_FIRST_TYPE = 1'b0;
   localparam logic CSR_SRH_TYPE   = 1'b1;

   typedef struct packed {
      logic       last_byte;
      logic [7:0] pkt_byte;
   } item_type;

   typedef struct packed {
      logic [3:0] headers_walked;
      logic [7:0] srh_offset;
      logic       srh_found;
      logic [7:0] tcp_offset;
      logic [2:0] status;
   } result_type;

   function automatic logic supported(input logic [7:0] t);
      return (t == PROTO_IPIP) || (t == PROTO_TCP) || (t == PROTO_IPV6) ||
             (t == PROTO_ROUTING);
   endfunction

endpackage

// File: hdl/ipv6_header_chain_walker.sv
// ----------------------------------------------------------------------------
// ipv6_header_chain_walker
// Walks an IPv6 header chain byte by byte and gives one verdict per packet.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock on req_ and gives one verdict per packet on
// rsp_, loaded into the result register once the deciding byte has passed
// the input register. Each byte is handled by the compare-and-capture step
// between the two registers, so the sustained rate is one byte per cycle; the
// result register only stalls the input while a verdict waits on rsp_tready.
// Bytes after a verdict are consumed silently up to tlast. csr_ writes must be
// made only while no packet is in flight; the block does not enforce this.
module ipv6_header_chain_walker #(
   parameter int MAX_DEPTH     = hcw_pkg::DEF_MAX_DEPTH,
   parameter int OFFSET_LIMIT  = hcw_pkg::DEF_OFFSET_LIMIT,
   parameter int POSITION_BITS = hcw_pkg::DEF_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pkt_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] status, [10:3] tcp_offset,
                                    // [11] srh_found, [19:12] srh_offset,
                                    // [23:20] headers_walked
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import hcw_pkg::*;

   logic [7:0] first_type_ff, first_type_in;
   logic [7:0] srh_type_ff, srh_type_in;

   item_type   req_item, walk_item;
   result_type walk_result, rsp_result;
   logic       walk_valid, walk_step, walk_hit, out_can_load, out_load;

   always_comb begin
      first_type_in = first_type_ff;
      srh_type_in   = srh_type_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_TYPE: first_type_in = csr_wdata;
            CSR_SRH_TYPE:   srh_type_in   = csr_wdata;
            default:        first_type_in = first_type_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_type_ff <= FIRST_TYPE_RESET;
         srh_type_ff   <= SRH_TYPE_RESET;
      end else begin
         first_type_ff <= first_type_in;
         srh_type_ff   <= srh_type_in;
      end
   end

   assign req_item.pkt_byte  = req_tdata;
   assign req_item.last_byte = req_tlast;

   hcw_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (walk_valid),
      .out_take  (walk_step),
      .out_item  (walk_item)
   );

   assign walk_step = walk_valid && (out_can_load || !walk_hit);
   assign out_load  = walk_step && walk_hit;

   hcw_walk #(
      .MAX_DEPTH     (MAX_DEPTH),
      .OFFSET_LIMIT  (OFFSET_LIMIT),
      .POSITION_BITS (POSITION_BITS)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .step       (walk_step),
      .item       (walk_item),
      .first_type (first_type_ff),
      .srh_type   (srh_type_ff),
      .hit        (walk_hit),
      .result     (walk_result)
   );

   hcw_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (out_load),
      .load_result (walk_result),
      .can_load    (out_can_load),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (rsp_result)
   );

   assign rsp_tdata = rsp_result;

   a_load_on_step: assert property (@(posedge clock) disable iff (reset)
      out_load |-> walk_valid && out_can_load)
      else $error("verdict loaded without a byte step");

   a_tcp_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result.status != ST_TCP_FOUND |-> rsp_result.tcp_offset == 8'd0)
      else $error("tcp offset set without tcp verdict");

   a_srh_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_result.srh_found |-> rsp_result.srh_offset == 8'd0)
      else $error("srh offset set without srh record");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_result.headers_walked <= 4'(MAX_DEPTH))
      else $error("header count beyond depth limit");

endmodule

// File: hdl/hcw_in_reg.sv
// ----------------------------------------------------------------------------
// hcw_in_reg
// Input register: holds one packet byte until the walker takes it.
// ----------------------------------------------------------------------------
module hcw_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hcw_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_take,
   output hcw_pkg::item_type out_item
);
   import hcw_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// File: hdl/hcw_walk.sv
// ----------------------------------------------------------------------------
// hcw_walk
// Per-packet chain state and the compare/capture step for one byte.
// ----------------------------------------------------------------------------
module hcw_walk #(
   parameter int MAX_DEPTH     = hcw_pkg::DEF_MAX_DEPTH,
   parameter int OFFSET_LIMIT  = hcw_pkg::DEF_OFFSET_LIMIT,
   parameter int POSITION_BITS = hcw_pkg::DEF_POSITION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  hcw_pkg::item_type   item,
   input  logic [7:0]          first_type,
   input  logic [7:0]          srh_type,
   output logic                hit,
   output hcw_pkg::result_type result
);
   import hcw_pkg::*;

   localparam int HS_BITS = $clog2(OFFSET_LIMIT + 1);
   localparam int WA      = (POSITION_BITS > HS_BITS) ? POSITION_BITS : HS_BITS;
   localparam int W       = ((WA > 12) ? WA : 12) + 1;
   localparam logic [W-1:0] POS_MAX = W'((1 << POSITION_BITS) - 1);
   localparam logic [W-1:0] LIMIT   = W'(OFFSET_LIMIT);
   localparam logic [3:0]   DEPTH   = 4'(MAX_DEPTH);

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [HS_BITS-1:0]       hstart_ff, hstart_in;
   logic [7:0]               ctype_ff, ctype_in;
   logic [7:0]               cnext_ff, cnext_in;
   logic [7:0]               clen_ff, clen_in;
   logic [7:0]               crt_ff, crt_in;
   logic [3:0]               hcount_ff, hcount_in;
   logic                     srh_seen_ff, srh_seen_in;
   logic [7:0]               srh_pos_ff, srh_pos_in;
   logic                     done_ff, done_in;

   logic [7:0]   cur_type;
   logic [W-1:0] p_w, hs_w, rel_w, adv_size, start_w, rt_size;
   logic [7:0]   adv_next;
   logic         adv;
   logic [3:0]   cnt1;
   logic [2:0]   status;
   logic [7:0]   tcp_off;

   always_comb begin
      cur_type    = (pos_ff == '0) ? first_type : ctype_ff;
      p_w         = W'(pos_ff);
      hs_w        = W'(hstart_ff);
      rel_w       = p_w - hs_w;
      rt_size     = (W'(clen_ff) + W'(1)) << 3;
      start_w     = '0;
      cnt1        = hcount_ff + 4'd1;
      adv         = 1'b0;
      adv_size    = '0;
      adv_next    = cnext_ff;
      hit         = 1'b0;
      status      = ST_TRUNCATED;
      tcp_off     = '0;
      pos_in      = pos_ff;
      hstart_in   = hstart_ff;
      ctype_in    = cur_type;
      cnext_in    = cnext_ff;
      clen_in     = clen_ff;
      crt_in      = crt_ff;
      hcount_in   = hcount_ff;
      srh_seen_in = srh_seen_ff;
      srh_pos_in  = srh_pos_ff;
      done_in     = done_ff;

      if (!done_ff) begin
         priority if (p_w >= POS_MAX) begin
            hit    = 1'b1;
            status = ST_OVERFLOW;
         end else if (!supported(cur_type)) begin
            hit    = 1'b1;
            status = ST_UNSUPPORTED;
         end else if (p_w >= hs_w) begin
            priority if (cur_type == PROTO_IPIP) begin
               if (rel_w == W'(0)) clen_in = {4'b0, item.pkt_byte[3:0]};
               if (rel_w == W'(9)) cnext_in = item.pkt_byte;
               if (rel_w == W'(19)) begin
                  if (clen_ff < 8'd5) begin
                     hit    = 1'b1;
                     status = ST_BAD_IHL;
                  end else begin
                     adv      = 1'b1;
                     adv_size = W'(clen_ff) << 2;
                  end
               end
            end else if (cur_type == PROTO_IPV6) begin
               if (rel_w == W'(6)) cnext_in = item.pkt_byte;
               if (rel_w == W'(39)) begin
                  adv      = 1'b1;
                  adv_size = W'(40);
               end
            end else if (cur_type == PROTO_ROUTING) begin
               if (rel_w == W'(0)) cnext_in = item.pkt_byte;
               if (rel_w == W'(1)) clen_in = item.pkt_byte;
               if (rel_w == W'(2)) crt_in = item.pkt_byte;
               if (rel_w == W'(3) && crt_ff == srh_type) begin
                  srh_seen_in = 1'b1;
                  srh_pos_in  = hs_w[7:0];
               end
               if (rel_w >= W'(3) && rel_w == rt_size - W'(1)) begin
                  adv      = 1'b1;
                  adv_size = rt_size;
               end
            end else begin
               if (rel_w == W'(19)) begin
                  hit     = 1'b1;
                  status  = ST_TCP_FOUND;
                  tcp_off = hs_w[7:0];
               end
            end
         end

         if (adv) begin
            hcount_in = cnt1;
            start_w   = hs_w + adv_size;
            priority if (cnt1 >= DEPTH) begin
               hit    = 1'b1;
               status = ST_DEPTH;
            end else if (start_w > LIMIT) begin
               hit    = 1'b1;
               status = ST_OVERFLOW;
            end else if (!supported(adv_next)) begin
               hit    = 1'b1;
               status = ST_UNSUPPORTED;
            end else begin
               hstart_in = start_w[HS_BITS-1:0];
               ctype_in  = adv_next;
            end
         end

         if (!hit && item.last_byte) begin
            hit    = 1'b1;
            status = ST_TRUNCATED;
         end
      end

      result.status         = status;
      result.tcp_offset     = tcp_off;
      result.srh_found      = srh_seen_in;
      result.srh_offset     = srh_pos_in;
      result.headers_walked = hcount_in;

      if (hit) done_in = 1'b1;

      if (item.last_byte) begin
         pos_in      = '0;
         hstart_in   = '0;
         ctype_in    = first_type;
         cnext_in    = '0;
         clen_in     = '0;
         crt_in      = '0;
         hcount_in   = '0;
         srh_seen_in = 1'b0;
         srh_pos_in  = '0;
         done_in     = 1'b0;
      end else if (pos_ff != '1) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hstart_ff   <= '0;
         ctype_ff    <= FIRST_TYPE_RESET;
         cnext_ff    <= '0;
         clen_ff     <= '0;
         crt_ff      <= '0;
         hcount_ff   <= '0;
         srh_seen_ff <= 1'b0;
         srh_pos_ff  <= '0;
         done_ff     <= 1'b0;
      end else if (step) begin
         pos_ff      <= pos_in;
         hstart_ff   <= hstart_in;
         ctype_ff    <= ctype_in;
         cnext_ff    <= cnext_in;
         clen_ff     <= clen_in;
         crt_ff      <= crt_in;
         hcount_ff   <= hcount_in;
         srh_seen_ff <= srh_seen_in;
         srh_pos_ff  <= srh_pos_in;
         done_ff     <= done_in;
      end
   end

endmodule

// File: hdl/hcw_out_reg.sv
// ----------------------------------------------------------------------------
// hcw_out_reg
// Result register: holds one verdict until the result side takes it.
// ----------------------------------------------------------------------------
module hcw_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  hcw_pkg::result_type load_result,
   output logic                can_load,
   output logic                out_valid,
   input  logic                out_ready,
   output hcw_pkg::result_type out_result
);
   import hcw_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign can_load   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (can_load) begin
         valid_in = load;
      end
      if (load) begin
         result_in = load_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

endmodule
